FILE: design/fisheye_pixel_to_sphere_angles_top_assert.svh
// Assertion macros shared by the checker.
`ifndef FISHEYE_PIXEL_TO_SPHERE_ANGLES_TOP_ASSERT_SVH
`define FISHEYE_PIXEL_TO_SPHERE_ANGLES_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define FPSA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define FPSA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/fpsa_pkg.sv
package fpsa_pkg;

    localparam int XW           = 51;   // signed Q.20 width of X and Y
    localparam int SQRT_STEPS   = 32;
    localparam int HORNER_STEPS = 4;
    localparam int CORDIC_ITERS = 24;
    // input decode, normalize, iterations, clamp
    localparam int CORDIC_LAT   = CORDIC_ITERS + 3;

    localparam logic [26:0] HALF_PI_Q24 = 27'd26353589;
    localparam logic [26:0] PI_Q24      = 27'd52707179;
    localparam logic [26:0] TWO_PI_Q24  = 27'd105414357;

    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

    localparam logic [23:0] ATAN_TAB [CORDIC_ITERS] = '{
        24'd13176795, 24'd7778716, 24'd4110060, 24'd2086331,
        24'd1047214,  24'd524117,  24'd262123,  24'd131069,
        24'd65536,    24'd32768,   24'd16384,   24'd8192,
        24'd4096,     24'd2048,    24'd1024,    24'd512,
        24'd256,      24'd128,     24'd64,      24'd32,
        24'd16,       24'd8,       24'd4,       24'd2
    };

    typedef enum logic [2:0] {
        REG_AFFINE_C       = 3'd0,
        REG_AFFINE_D       = 3'd1,
        REG_AFFINE_E       = 3'd2,
        REG_OPTICAL_CENTER = 3'd3,
        REG_POLY_A0        = 3'd4,
        REG_POLY_A2        = 3'd5,
        REG_POLY_A3        = 3'd6,
        REG_POLY_A4        = 3'd7
    } reg_idx_t;

    // Per-pixel data that rides along the pipeline.
    typedef struct packed {
        logic [23:0]   color;      // {red, green, blue}
        logic          at_center;
        logic          x_neg;
        logic          y_neg;
        logic [XW-1:0] ax;
        logic [XW-1:0] ay;
    } side_t;

    // Position of the highest set bit, zero for an all-zero word.
    function automatic logic [5:0] msb_pos(input logic [63:0] v);
        logic [5:0] pos;
        pos = '0;
        for (int i = 0; i < 64; i++) begin
            if (v[i]) pos = 6'(i);
        end
        return pos;
    endfunction

endpackage

FILE: design/fpsa_cordic.sv
module fpsa_cordic (
    input  logic        aclk,
    input  logic        en,
    input  logic [63:0] x_in,
    input  logic [63:0] y_in,
    output logic [24:0] angle_out   // atan(y/x), Q.24 radians, 0..pi/2
);

    localparam int N = fpsa_pkg::CORDIC_ITERS;

    logic [63:0] xa_reg, ya_reg;
    logic        zero_a_reg;
    logic [5:0]  msb_reg;
    logic [63:0] xs_next, ys_next;

    logic signed [63:0] x_reg [N+1];
    logic signed [63:0] y_reg [N+1];
    logic signed [27:0] z_reg [N+1];
    logic               zero_reg [N+1];

    logic signed [27:0] half_pi;
    logic [24:0]        angle_next;

    // decode: capture the operands and locate the leading one
    always_ff @(posedge aclk) begin
        if (en) begin
            xa_reg     <= x_in;
            ya_reg     <= y_in;
            zero_a_reg <= ((x_in | y_in) == 64'd0);
            msb_reg    <= fpsa_pkg::msb_pos(x_in | y_in);
        end
    end

    // normalize so that the leading one sits at bit 59
    always_comb begin
        if (msb_reg >= 6'd59) begin
            xs_next = xa_reg >> (msb_reg - 6'd59);
            ys_next = ya_reg >> (msb_reg - 6'd59);
        end else begin
            xs_next = xa_reg << (6'd59 - msb_reg);
            ys_next = ya_reg << (6'd59 - msb_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]    <= $signed({4'b0, xs_next[59:0]});
            y_reg[0]    <= $signed({4'b0, ys_next[59:0]});
            z_reg[0]    <= '0;
            zero_reg[0] <= zero_a_reg;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_iter
        always_ff @(posedge aclk) begin
            if (en) begin
                if (y_reg[i] >= 0) begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + $signed({4'b0, fpsa_pkg::ATAN_TAB[i]});
                end else begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - $signed({4'b0, fpsa_pkg::ATAN_TAB[i]});
                end
                zero_reg[i+1] <= zero_reg[i];
            end
        end
    end

    // clamp to 0..pi/2
    assign half_pi = $signed({1'b0, fpsa_pkg::HALF_PI_Q24});

    always_comb begin
        if (zero_reg[N] || z_reg[N] < 0) begin
            angle_next = '0;
        end else if (z_reg[N] > half_pi) begin
            angle_next = fpsa_pkg::HALF_PI_Q24[24:0];
        end else begin
            angle_next = z_reg[N][24:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            angle_out <= angle_next;
        end
    end

endmodule

FILE: design/fisheye_pixel_to_sphere_angles_top.sv
// Throughput: one pixel per clock; every stage is registered and the whole
//   pipeline holds while a finished result waits on m_tready.
// Reset: synchronous, active-low aresetn clears all valid bits and loads the
//   configuration registers with their defaults (affine_c = 1.0, rest zero).
module fisheye_pixel_to_sphere_angles_top #(
    parameter int IMAGE_ROWS = 4096,
    parameter int IMAGE_COLS = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input pixel
    input  logic        s_tvalid,
    output logic        s_tready,
    // [15:0] row_pos, [31:16] col_pos, [39:32] blue_in, [47:40] green_in,
    // [55:48] red_in
    input  logic [55:0] s_tdata,
    // result
    output logic        m_tvalid,
    input  logic        m_tready,
    // [17:0] polar_angle, [36:18] azimuth_angle, [44:37] blue_out,
    // [52:45] green_out, [60:53] red_out, [63:61] zero
    output logic [63:0] m_tdata,
    // [0] at_center
    output logic [0:0]  m_tuser,
    // configuration write port
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [63:0] cfg_wdata
);

    localparam int XW = fpsa_pkg::XW;
    localparam int SQ = fpsa_pkg::SQRT_STEPS;
    localparam int HS = fpsa_pkg::HORNER_STEPS;
    localparam int CL = fpsa_pkg::CORDIC_LAT;

    // clamp limits for the last valid row and column, Q12.4
    localparam logic [15:0] ROW_MAX = 16'((IMAGE_ROWS - 1) * 16);
    localparam logic [15:0] COL_MAX = 16'((IMAGE_COLS - 1) * 16);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [31:0] affine_c_reg, affine_d_reg, affine_e_reg, poly_a0_reg;
    logic        [63:0] optical_center_reg;
    logic signed [63:0] poly_a2_reg, poly_a3_reg, poly_a4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            affine_c_reg       <= 32'sd65536;
            affine_d_reg       <= '0;
            affine_e_reg       <= '0;
            optical_center_reg <= '0;
            poly_a0_reg        <= '0;
            poly_a2_reg        <= '0;
            poly_a3_reg        <= '0;
            poly_a4_reg        <= '0;
        end else if (cfg_we) begin
            unique case (fpsa_pkg::reg_idx_t'(cfg_addr))
                fpsa_pkg::REG_AFFINE_C:       affine_c_reg       <= cfg_wdata[31:0];
                fpsa_pkg::REG_AFFINE_D:       affine_d_reg       <= cfg_wdata[31:0];
                fpsa_pkg::REG_AFFINE_E:       affine_e_reg       <= cfg_wdata[31:0];
                fpsa_pkg::REG_OPTICAL_CENTER: optical_center_reg <= cfg_wdata;
                fpsa_pkg::REG_POLY_A0:        poly_a0_reg        <= cfg_wdata[31:0];
                fpsa_pkg::REG_POLY_A2:        poly_a2_reg        <= cfg_wdata;
                fpsa_pkg::REG_POLY_A3:        poly_a3_reg        <= cfg_wdata;
                fpsa_pkg::REG_POLY_A4:        poly_a4_reg        <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline advance: every stage moves when the output register is
    // empty or is being drained this cycle; otherwise everything holds.
    // ------------------------------------------------------------------
    logic m_tvalid_reg;
    logic adv;

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;

    // ------------------------------------------------------------------
    // Stage 1: clamp the position and form the affine products
    // ------------------------------------------------------------------
    logic [15:0]        u_next, v_next;
    logic signed [48:0] cu_next, du_next, eu_next;

    assign u_next  = (s_tdata[15:0]  > ROW_MAX) ? ROW_MAX : s_tdata[15:0];
    assign v_next  = (s_tdata[31:16] > COL_MAX) ? COL_MAX : s_tdata[31:16];
    assign cu_next = affine_c_reg * $signed({1'b0, u_next});
    assign du_next = affine_d_reg * $signed({1'b0, v_next});
    assign eu_next = affine_e_reg * $signed({1'b0, u_next});

    logic               p1_valid_reg;
    logic signed [48:0] p1_cu_reg, p1_du_reg, p1_eu_reg;
    logic [15:0]        p1_v_reg;
    logic [23:0]        p1_color_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (adv) begin
            p1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_cu_reg    <= cu_next;
            p1_du_reg    <= du_next;
            p1_eu_reg    <= eu_next;
            p1_v_reg     <= v_next;
            p1_color_reg <= s_tdata[55:32];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: X = c*u + d*v - u0, Y = e*u + v - v0 (signed Q.20)
    // ------------------------------------------------------------------
    logic signed [XW-1:0] x_next, y_next;

    assign x_next = XW'(p1_cu_reg) + XW'(p1_du_reg)
                  - $signed({15'b0, optical_center_reg[63:32], 4'b0});
    assign y_next = XW'(p1_eu_reg) + $signed({19'b0, p1_v_reg, 16'b0})
                  - $signed({15'b0, optical_center_reg[31:0], 4'b0});

    logic                 p2_valid_reg;
    logic signed [XW-1:0] p2_x_reg, p2_y_reg;
    logic [23:0]          p2_color_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
        end else if (adv) begin
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p2_x_reg     <= x_next;
            p2_y_reg     <= y_next;
            p2_color_reg <= p1_color_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: magnitudes, quadrant flags, center detect
    // ------------------------------------------------------------------
    fpsa_pkg::side_t side3_next;

    always_comb begin
        side3_next.color     = p2_color_reg;
        side3_next.at_center = (p2_x_reg == '0) && (p2_y_reg == '0);
        side3_next.x_neg     = p2_x_reg[XW-1];
        side3_next.y_neg     = p2_y_reg[XW-1];
        side3_next.ax        = p2_x_reg[XW-1] ? XW'(-p2_x_reg) : XW'(p2_x_reg);
        side3_next.ay        = p2_y_reg[XW-1] ? XW'(-p2_y_reg) : XW'(p2_y_reg);
    end

    logic            p3_valid_reg;
    fpsa_pkg::side_t p3_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p3_valid_reg <= 1'b0;
        end else if (adv) begin
            p3_valid_reg <= p2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p3_side_reg <= side3_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: pick the right shift that brings both magnitudes below
    // 2^31 so that the squares fit a 31x31 multiplier
    // ------------------------------------------------------------------
    logic [5:0] len_msb;
    logic [4:0] len_s_next;

    assign len_msb    = fpsa_pkg::msb_pos(64'(p3_side_reg.ax | p3_side_reg.ay));
    assign len_s_next = (len_msb >= 6'd31) ? 5'(len_msb - 6'd30) : 5'd0;

    logic            p4_valid_reg;
    fpsa_pkg::side_t p4_side_reg;
    logic [4:0]      p4_s_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p4_valid_reg <= 1'b0;
        end else if (adv) begin
            p4_valid_reg <= p3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p4_side_reg <= p3_side_reg;
            p4_s_reg    <= len_s_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: shift; stage 6: square; stage 7: sum of squares
    // ------------------------------------------------------------------
    logic [XW-1:0] axs_next, ays_next;

    assign axs_next = p4_side_reg.ax >> p4_s_reg;
    assign ays_next = p4_side_reg.ay >> p4_s_reg;

    logic            p5_valid_reg;
    fpsa_pkg::side_t p5_side_reg;
    logic [4:0]      p5_s_reg;
    logic [30:0]     p5_axn_reg, p5_ayn_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p5_valid_reg <= 1'b0;
        end else if (adv) begin
            p5_valid_reg <= p4_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p5_side_reg <= p4_side_reg;
            p5_s_reg    <= p4_s_reg;
            p5_axn_reg  <= axs_next[30:0];
            p5_ayn_reg  <= ays_next[30:0];
        end
    end

    logic [61:0] sqx_next, sqy_next;

    assign sqx_next = p5_axn_reg * p5_axn_reg;
    assign sqy_next = p5_ayn_reg * p5_ayn_reg;

    logic            p6_valid_reg;
    fpsa_pkg::side_t p6_side_reg;
    logic [4:0]      p6_s_reg;
    logic [61:0]     p6_sqx_reg, p6_sqy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p6_valid_reg <= 1'b0;
        end else if (adv) begin
            p6_valid_reg <= p5_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p6_side_reg <= p5_side_reg;
            p6_s_reg    <= p5_s_reg;
            p6_sqx_reg  <= sqx_next;
            p6_sqy_reg  <= sqy_next;
        end
    end

    // ------------------------------------------------------------------
    // Square root: one result bit per stage, digit-by-digit.
    // Entry 0 is loaded with the sum of squares (stage 7).
    // ------------------------------------------------------------------
    logic            sq_valid_reg [SQ+1];
    fpsa_pkg::side_t sq_side_reg  [SQ+1];
    logic [4:0]      sq_s_reg     [SQ+1];
    logic [63:0]     sq_n_reg     [SQ+1];
    logic [63:0]     sq_res_reg   [SQ+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_valid_reg[0] <= 1'b0;
        end else if (adv) begin
            sq_valid_reg[0] <= p6_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sq_side_reg[0] <= p6_side_reg;
            sq_s_reg[0]    <= p6_s_reg;
            sq_n_reg[0]    <= 64'(p6_sqx_reg) + 64'(p6_sqy_reg);
            sq_res_reg[0]  <= '0;
        end
    end

    for (genvar k = 0; k < SQ; k++) begin : g_sqrt
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);

        logic [63:0] trial;

        assign trial = sq_res_reg[k] + BIT;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_valid_reg[k+1] <= 1'b0;
            end else if (adv) begin
                sq_valid_reg[k+1] <= sq_valid_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                sq_side_reg[k+1] <= sq_side_reg[k];
                sq_s_reg[k+1]    <= sq_s_reg[k];
                if (sq_n_reg[k] >= trial) begin
                    sq_n_reg[k+1]   <= sq_n_reg[k] - trial;
                    sq_res_reg[k+1] <= (sq_res_reg[k] >> 1) + BIT;
                end else begin
                    sq_n_reg[k+1]   <= sq_n_reg[k];
                    sq_res_reg[k+1] <= sq_res_reg[k] >> 1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Undo the pre-shift and drop to Q.16
    // ------------------------------------------------------------------
    logic [52:0] r_full_next;

    assign r_full_next = 53'(sq_res_reg[SQ][31:0]) << sq_s_reg[SQ];

    logic            r16_valid_reg;
    fpsa_pkg::side_t r16_side_reg;
    logic [47:0]     r16_rs_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r16_valid_reg <= 1'b0;
        end else if (adv) begin
            r16_valid_reg <= sq_valid_reg[SQ];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            r16_side_reg <= sq_side_reg[SQ];
            r16_rs_reg   <= r_full_next[51:4];
        end
    end

    // ------------------------------------------------------------------
    // Horner evaluation of Z: four multiply-accumulate steps, each cut
    // into magnitude, partial products, sum, scale/saturate and add.
    //   step 0: a3 + a4*r   step 1: a2 + t*r   step 2: t*r
    //   step 3: a0 + t*r (scaled by 2^-48)
    // ------------------------------------------------------------------
    logic               h_valid_in [HS];
    fpsa_pkg::side_t    h_side_in  [HS];
    logic [47:0]        h_rs_in    [HS];
    logic signed [63:0] h_t_in     [HS];
    logic signed [63:0] h_coef     [HS];

    logic               hm0_valid_reg [HS];
    fpsa_pkg::side_t    hm0_side_reg  [HS];
    logic [47:0]        hm0_rs_reg    [HS];
    logic [63:0]        hm0_ua_reg    [HS];
    logic               hm0_neg_reg   [HS];

    logic               hm1_valid_reg [HS];
    fpsa_pkg::side_t    hm1_side_reg  [HS];
    logic [47:0]        hm1_rs_reg    [HS];
    logic               hm1_neg_reg   [HS];
    logic [63:0]        hm1_p00_reg   [HS];
    logic [47:0]        hm1_p01_reg   [HS];
    logic [63:0]        hm1_p10_reg   [HS];
    logic [47:0]        hm1_p11_reg   [HS];

    logic               hm2_valid_reg [HS];
    fpsa_pkg::side_t    hm2_side_reg  [HS];
    logic [47:0]        hm2_rs_reg    [HS];
    logic               hm2_neg_reg   [HS];
    logic [111:0]       hm2_prod_reg  [HS];

    logic               hm3_valid_reg [HS];
    fpsa_pkg::side_t    hm3_side_reg  [HS];
    logic [47:0]        hm3_rs_reg    [HS];
    logic signed [63:0] hm3_m_reg     [HS];

    logic               ha_valid_reg  [HS];
    fpsa_pkg::side_t    ha_side_reg   [HS];
    logic [47:0]        ha_rs_reg     [HS];
    logic signed [63:0] ha_t_reg      [HS];

    assign h_valid_in[0] = r16_valid_reg;
    assign h_side_in[0]  = r16_side_reg;
    assign h_rs_in[0]    = r16_rs_reg;
    assign h_t_in[0]     = poly_a4_reg;

    assign h_coef[0] = poly_a3_reg;
    assign h_coef[1] = poly_a2_reg;
    assign h_coef[2] = '0;
    assign h_coef[3] = {{32{poly_a0_reg[31]}}, poly_a0_reg};

    for (genvar k = 0; k < HS; k++) begin : g_horner
        localparam int SH = (k == HS - 1) ? 48 : 16;
        localparam logic signed [64:0] SUM_MAX = 65'sh0_7FFF_FFFF_FFFF_FFFF;
        localparam logic signed [64:0] SUM_MIN = -SUM_MAX;

        logic [111:0]       q_full;
        logic [63:0]        q_mag;
        logic signed [63:0] m_next;
        logic signed [64:0] sum_next;
        logic signed [63:0] t_next;

        if (k > 0) begin : g_link
            assign h_valid_in[k] = ha_valid_reg[k-1];
            assign h_side_in[k]  = ha_side_reg[k-1];
            assign h_rs_in[k]    = ha_rs_reg[k-1];
            assign h_t_in[k]     = ha_t_reg[k-1];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                hm0_valid_reg[k] <= 1'b0;
                hm1_valid_reg[k] <= 1'b0;
                hm2_valid_reg[k] <= 1'b0;
                hm3_valid_reg[k] <= 1'b0;
                ha_valid_reg[k]  <= 1'b0;
            end else if (adv) begin
                hm0_valid_reg[k] <= h_valid_in[k];
                hm1_valid_reg[k] <= hm0_valid_reg[k];
                hm2_valid_reg[k] <= hm1_valid_reg[k];
                hm3_valid_reg[k] <= hm2_valid_reg[k];
                ha_valid_reg[k]  <= hm3_valid_reg[k];
            end
        end

        // magnitude of the running term; the radius is never negative
        always_ff @(posedge aclk) begin
            if (adv) begin
                hm0_side_reg[k] <= h_side_in[k];
                hm0_rs_reg[k]   <= h_rs_in[k];
                hm0_neg_reg[k]  <= h_t_in[k][63];
                hm0_ua_reg[k]   <= h_t_in[k][63] ? (64'd0 - h_t_in[k]) : h_t_in[k];
            end
        end

        // 32-bit partial products
        always_ff @(posedge aclk) begin
            if (adv) begin
                hm1_side_reg[k] <= hm0_side_reg[k];
                hm1_rs_reg[k]   <= hm0_rs_reg[k];
                hm1_neg_reg[k]  <= hm0_neg_reg[k];
                hm1_p00_reg[k]  <= hm0_ua_reg[k][31:0]  * hm0_rs_reg[k][31:0];
                hm1_p01_reg[k]  <= hm0_ua_reg[k][31:0]  * hm0_rs_reg[k][47:32];
                hm1_p10_reg[k]  <= hm0_ua_reg[k][63:32] * hm0_rs_reg[k][31:0];
                hm1_p11_reg[k]  <= hm0_ua_reg[k][63:32] * hm0_rs_reg[k][47:32];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                hm2_side_reg[k] <= hm1_side_reg[k];
                hm2_rs_reg[k]   <= hm1_rs_reg[k];
                hm2_neg_reg[k]  <= hm1_neg_reg[k];
                hm2_prod_reg[k] <= 112'(hm1_p00_reg[k])
                                 + (112'(hm1_p01_reg[k]) << 32)
                                 + (112'(hm1_p10_reg[k]) << 32)
                                 + (112'(hm1_p11_reg[k]) << 64);
            end
        end

        // scale, truncate toward zero, saturate, restore the sign
        assign q_full = hm2_prod_reg[k] >> SH;
        assign q_mag  = (|q_full[111:63]) ? fpsa_pkg::S64_MAX : {1'b0, q_full[62:0]};
        assign m_next = hm2_neg_reg[k] ? $signed(64'd0 - q_mag) : $signed(q_mag);

        always_ff @(posedge aclk) begin
            if (adv) begin
                hm3_side_reg[k] <= hm2_side_reg[k];
                hm3_rs_reg[k]   <= hm2_rs_reg[k];
                hm3_m_reg[k]    <= m_next;
            end
        end

        // saturating add; a zero product leaves the coefficient untouched
        assign sum_next = $signed({h_coef[k][63], h_coef[k]})
                        + $signed({hm3_m_reg[k][63], hm3_m_reg[k]});

        always_comb begin
            if (hm3_m_reg[k] == '0) begin
                t_next = h_coef[k];
            end else if (sum_next > SUM_MAX) begin
                t_next = fpsa_pkg::S64_MAX;
            end else if (sum_next < SUM_MIN) begin
                t_next = -fpsa_pkg::S64_MAX;
            end else begin
                t_next = sum_next[63:0];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                ha_side_reg[k] <= hm3_side_reg[k];
                ha_rs_reg[k]   <= hm3_rs_reg[k];
                ha_t_reg[k]    <= t_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Z magnitude and sign for the polar angle
    // ------------------------------------------------------------------
    logic            zs_valid_reg;
    fpsa_pkg::side_t zs_side_reg;
    logic [47:0]     zs_rs_reg;
    logic [63:0]     zs_mag_reg;
    logic            zs_neg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zs_valid_reg <= 1'b0;
        end else if (adv) begin
            zs_valid_reg <= ha_valid_reg[HS-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            zs_side_reg <= ha_side_reg[HS-1];
            zs_rs_reg   <= ha_rs_reg[HS-1];
            zs_neg_reg  <= ha_t_reg[HS-1][63];
            zs_mag_reg  <= ha_t_reg[HS-1][63] ? (64'd0 - ha_t_reg[HS-1]) : ha_t_reg[HS-1];
        end
    end

    // ------------------------------------------------------------------
    // Angle units: theta from (|Z|, r), phi from (|X|, |Y|), in parallel.
    // The side data waits in a delay line of the same length.
    // ------------------------------------------------------------------
    logic [24:0] theta_a, phi_a;

    fpsa_cordic u_theta_cordic (
        .aclk      (aclk),
        .en        (adv),
        .x_in      (zs_mag_reg),
        .y_in      (64'(zs_rs_reg)),
        .angle_out (theta_a)
    );

    fpsa_cordic u_phi_cordic (
        .aclk      (aclk),
        .en        (adv),
        .x_in      (64'(zs_side_reg.ax)),
        .y_in      (64'(zs_side_reg.ay)),
        .angle_out (phi_a)
    );

    logic            dl_valid_reg [CL];
    fpsa_pkg::side_t dl_side_reg  [CL];
    logic            dl_zneg_reg  [CL];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dl_valid_reg[0] <= 1'b0;
        end else if (adv) begin
            dl_valid_reg[0] <= zs_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dl_side_reg[0] <= zs_side_reg;
            dl_zneg_reg[0] <= zs_neg_reg;
        end
    end

    for (genvar i = 1; i < CL; i++) begin : g_delay
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dl_valid_reg[i] <= 1'b0;
            end else if (adv) begin
                dl_valid_reg[i] <= dl_valid_reg[i-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                dl_side_reg[i] <= dl_side_reg[i-1];
                dl_zneg_reg[i] <= dl_zneg_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Quadrant fold and round half up to Q.16
    // ------------------------------------------------------------------
    fpsa_pkg::side_t fin_side;
    logic [26:0]     theta24_next, phi24_next;
    logic [27:0]     theta_rnd, phi_rnd;
    logic [17:0]     polar_next;
    logic [18:0]     azimuth_next;

    assign fin_side = dl_side_reg[CL-1];

    always_comb begin
        theta24_next = dl_zneg_reg[CL-1] ? (fpsa_pkg::PI_Q24 - 27'(theta_a))
                                         : 27'(theta_a);
        if (!fin_side.x_neg && !fin_side.y_neg) begin
            phi24_next = fpsa_pkg::PI_Q24 + 27'(phi_a);
        end else if (fin_side.x_neg && !fin_side.y_neg) begin
            phi24_next = fpsa_pkg::TWO_PI_Q24 - 27'(phi_a);
        end else if (fin_side.x_neg) begin
            phi24_next = 27'(phi_a);
        end else begin
            phi24_next = fpsa_pkg::PI_Q24 - 27'(phi_a);
        end
    end

    assign theta_rnd    = 28'(theta24_next) + 28'd128;
    assign phi_rnd      = 28'(phi24_next) + 28'd128;
    // at the optical center both angles report zero
    assign polar_next   = fin_side.at_center ? 18'd0 : theta_rnd[25:8];
    assign azimuth_next = fin_side.at_center ? 19'd0 : phi_rnd[26:8];

    // ------------------------------------------------------------------
    // Output register: holds a result until the transaction completes
    // ------------------------------------------------------------------
    logic [63:0] m_tdata_reg;
    logic        m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= dl_valid_reg[CL-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tdata_reg <= {3'b0, fin_side.color, azimuth_next, polar_next};
            m_tuser_reg <= fin_side.at_center;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

endmodule

FILE: design/fpsa_checker.sv
`include "fisheye_pixel_to_sphere_angles_top_assert.svh"

module fpsa_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [0:0]  m_tuser
);

    logic        stalled;
    logic [64:0] out_word;
    logic        angles_zero;
    logic        in_range;

    assign stalled     = m_tvalid && !m_tready;
    assign out_word    = {m_tuser, m_tdata};
    assign angles_zero = (m_tdata[36:0] == 37'd0);
    assign in_range    = (m_tdata[17:0] <= 18'd205887) && (m_tdata[36:18] <= 19'd411775);

    // a stalled result holds its value
    `FPSA_ASSERT_NEXT(a_out_hold, stalled, m_tvalid && $stable(out_word), "stalled result changed")

    // an empty output never back-pressures the input
    `FPSA_ASSERT_SAME(a_ready_when_empty, !m_tvalid, s_tready, "input stalled with empty output")

    // a pixel at the optical center reports zero angles
    `FPSA_ASSERT_SAME(a_center_zero, m_tvalid && m_tuser[0], angles_zero, "nonzero angles at center")

    // angles stay within 0..pi and 0..2pi
    `FPSA_ASSERT_SAME(a_angle_range, m_tvalid, in_range, "angle out of range")

    // padding bits stay zero
    `FPSA_ASSERT_SAME(a_pad_zero, m_tvalid, m_tdata[63:61] == 3'd0, "padding bits set")

endmodule

bind fisheye_pixel_to_sphere_angles_top fpsa_checker u_fpsa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

FILE: bench/tb_top.sv
module tb_top;

    // Expected contents of one result transaction.
    typedef struct {
        logic [17:0] polar;
        logic [18:0] azimuth;
        logic        centered;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
    } ray_t;

    // Angle predictor plus the queue of rays still owed by the pipeline.
    class ray_scoreboard;
        longint         cam_c, cam_d, cam_e, coef_a0, coef_a2, coef_a3, coef_a4;
        logic [63:0]    center;
        ray_t           owed[$];
        int             errors;
        int             checked;

        function new();
            cam_c = 65536; cam_d = 0; cam_e = 0; center = '0;
            coef_a0 = 0; coef_a2 = 0; coef_a3 = 0; coef_a4 = 0;
            errors = 0; checked = 0;
        endfunction

        function void set_reg(fpsa_pkg::reg_idx_t idx, logic [63:0] v);
            case (idx)
                fpsa_pkg::REG_AFFINE_C:       cam_c = longint'($signed(v[31:0]));
                fpsa_pkg::REG_AFFINE_D:       cam_d = longint'($signed(v[31:0]));
                fpsa_pkg::REG_AFFINE_E:       cam_e = longint'($signed(v[31:0]));
                fpsa_pkg::REG_OPTICAL_CENTER: center = v;
                fpsa_pkg::REG_POLY_A0:        coef_a0 = longint'($signed(v[31:0]));
                fpsa_pkg::REG_POLY_A2:        coef_a2 = $signed(v);
                fpsa_pkg::REG_POLY_A3:        coef_a3 = $signed(v);
                fpsa_pkg::REG_POLY_A4:        coef_a4 = $signed(v);
                default: ;
            endcase
        endfunction

        function int pending();
            return owed.size();
        endfunction

        function logic [63:0] magnitude(longint v);
            logic [63:0] u;
            u = v;
            return v < 0 ? 64'd0 - u : u;
        endfunction

        // Clamp a 65-bit sum to +-(2^63-1).
        function longint clamp_add(longint a, longint b);
            logic signed [64:0] s;
            s = 65'(a) + 65'(b);
            if (s > 65'(fpsa_pkg::S64_MAX)) return fpsa_pkg::S64_MAX;
            if (s < -65'(fpsa_pkg::S64_MAX)) return -fpsa_pkg::S64_MAX;
            return longint'(s);
        endfunction

        // (a*b) >> sh, truncated toward zero, clamped.
        function longint scaled_product(longint a, longint b, int sh);
            logic [127:0] p;
            longint q;
            p = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
            p = p >> sh;
            q = (p[127:63] != 0) ? fpsa_pkg::S64_MAX : longint'({1'b0, p[62:0]});
            return ((a < 0) != (b < 0)) ? -q : q;
        endfunction

        function logic [63:0] int_sqrt(logic [63:0] n);
            logic [63:0] res, bit_w;
            res = 0;
            bit_w = 64'd1 << 62;
            while (bit_w > n) bit_w = bit_w >> 2;
            while (bit_w != 0) begin
                if (n >= res + bit_w) begin
                    n = n - (res + bit_w);
                    res = (res >> 1) + bit_w;
                end else begin
                    res = res >> 1;
                end
                bit_w = bit_w >> 2;
            end
            return res;
        endfunction

        function logic [63:0] radius(logic [63:0] ax, logic [63:0] ay);
            int s;
            s = 0;
            while (ax >= (64'd1 << 31) || ay >= (64'd1 << 31)) begin
                ax = ax >> 1; ay = ay >> 1; s++;
            end
            return int_sqrt(ax * ax + ay * ay) << s;
        endfunction

        // atan(ay/ax) in Q.24, held to 0..pi/2.
        function longint vector_angle(logic [63:0] ax, logic [63:0] ay);
            longint x, y, z, dx, dy;
            z = 0;
            if (ax == 0 && ay == 0) return 0;
            while (ax >= (64'd1 << 60) || ay >= (64'd1 << 60)) begin
                ax = ax >> 1; ay = ay >> 1;
            end
            while (ax < (64'd1 << 59) && ay < (64'd1 << 59)) begin
                ax = ax << 1; ay = ay << 1;
            end
            x = ax; y = ay;
            for (int i = 0; i < fpsa_pkg::CORDIC_ITERS; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0) begin
                    x += dx; y -= dy; z += longint'(fpsa_pkg::ATAN_TAB[i]);
                end else begin
                    x -= dx; y += dy; z -= longint'(fpsa_pkg::ATAN_TAB[i]);
                end
            end
            if (z < 0) z = 0;
            if (z > longint'(fpsa_pkg::HALF_PI_Q24)) z = longint'(fpsa_pkg::HALF_PI_Q24);
            return z;
        endfunction

        function logic [63:0] round_q16(longint q24);
            return (q24 + 128) >> 8;
        endfunction

        function void note_pixel(logic [55:0] d);
            ray_t        e;
            longint      u, v, x, y, t, z, a, rs, pi_v, two_pi_v;
            logic [63:0] ax, ay, r16;
            u = d[15:0] > 16'd65520 ? 65520 : d[15:0];
            v = d[31:16] > 16'd65520 ? 65520 : d[31:16];
            pi_v = longint'(fpsa_pkg::PI_Q24);
            two_pi_v = longint'(fpsa_pkg::TWO_PI_Q24);
            x = cam_c * u + cam_d * v - longint'(center[63:32]) * 16;
            y = cam_e * u + v * 65536 - longint'(center[31:0]) * 16;
            e.blue = d[39:32]; e.green = d[47:40]; e.red = d[55:48];
            e.centered = (x == 0 && y == 0);
            e.polar = 0; e.azimuth = 0;
            if (!e.centered) begin
                ax = magnitude(x); ay = magnitude(y);
                r16 = radius(ax, ay) >> 4;
                rs = r16;
                // Horner evaluation of the axis term
                t = clamp_add(coef_a3, scaled_product(coef_a4, rs, 16));
                t = clamp_add(coef_a2, scaled_product(t, rs, 16));
                t = scaled_product(t, rs, 16);
                z = clamp_add(coef_a0, scaled_product(t, rs, 48));
                a = vector_angle(magnitude(z), r16);
                e.polar = 18'(round_q16(z >= 0 ? a : pi_v - a));
                a = vector_angle(ax, ay);
                if (x >= 0 && y >= 0)     e.azimuth = 19'(round_q16(pi_v + a));
                else if (x < 0 && y >= 0) e.azimuth = 19'(round_q16(two_pi_v - a));
                else if (x < 0)           e.azimuth = 19'(round_q16(a));
                else                      e.azimuth = 19'(round_q16(pi_v - a));
            end
            owed = {owed, e};
        endfunction

        task report(string field, longint want, longint got);
            errors++;
            if (errors <= 200)
                $display("MISMATCH ray %0d %s: expected %0d got %0d",
                         checked, field, want, got);
        endtask

        task check_ray(logic [63:0] d, logic [0:0] flag);
            ray_t e;
            if (owed.size() == 0) begin
                report("unexpected transaction", 0, d);
                return;
            end
            e = owed.pop_front();
            if (d[17:0] !== e.polar)     report("polar_angle", e.polar, d[17:0]);
            if (d[36:18] !== e.azimuth)  report("azimuth_angle", e.azimuth, d[36:18]);
            if (flag[0] !== e.centered)  report("at_center", e.centered, flag[0]);
            if (d[44:37] !== e.blue)     report("blue_out", e.blue, d[44:37]);
            if (d[52:45] !== e.green)    report("green_out", e.green, d[52:45]);
            if (d[60:53] !== e.red)      report("red_out", e.red, d[60:53]);
            if (d[63:61] !== 3'd0)       report("padding", 0, d[63:61]);
            checked++;
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_addr = '0;
    logic [63:0] cfg_wdata = '0;

    ray_scoreboard rays = new();
    int            pixels_sent = 0;
    int            settings_used = 0;

    fisheye_pixel_to_sphere_angles_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Sample both handshakes at the rising edge; inputs only move on the falling edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) rays.note_pixel(s_tdata);
            if (m_tvalid && m_tready) rays.check_ray(m_tdata, m_tuser);
        end
    end

    // Receiver back-pressure: rotate between always ready, coin toss, mostly ready and long stalls.
    int stall_mode = 0;
    int stall_left = 0;
    always @(negedge aclk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(10, 200);
        end
        stall_left--;
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= $urandom_range(0, 1);
            2:       m_tready <= ($urandom_range(0, 7) != 0);
            default: m_tready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    // Hand off one pixel; called at a falling edge, returns at a falling edge.
    task send_pixel(logic [15:0] row, logic [15:0] col, logic [23:0] bgr);
        s_tvalid <= 1'b1;
        s_tdata <= {bgr, col, row};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        pixels_sent++;
    endtask

    task idle_sender(int cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(negedge aclk);
    endtask

    // Hold one register write for a cycle; the caller drops the enable afterwards.
    task write_reg(fpsa_pkg::reg_idx_t idx, logic [63:0] v);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= v;
        rays.set_reg(idx, v);
        @(negedge aclk);
    endtask

    // Hold until every owed ray has come back, then let the pipe settle.
    task drain();
        s_tvalid <= 1'b0;
        while (rays.pending() != 0) @(negedge aclk);
        repeat (100) @(negedge aclk);
    endtask

    task load_setting(logic [63:0] c, logic [63:0] d, logic [63:0] e, logic [63:0] ctr,
                      logic [63:0] a0, logic [63:0] a2, logic [63:0] a3, logic [63:0] a4);
        write_reg(fpsa_pkg::REG_AFFINE_C, c);
        write_reg(fpsa_pkg::REG_AFFINE_D, d);
        write_reg(fpsa_pkg::REG_AFFINE_E, e);
        write_reg(fpsa_pkg::REG_OPTICAL_CENTER, ctr);
        write_reg(fpsa_pkg::REG_POLY_A0, a0);
        write_reg(fpsa_pkg::REG_POLY_A2, a2);
        write_reg(fpsa_pkg::REG_POLY_A3, a3);
        write_reg(fpsa_pkg::REG_POLY_A4, a4);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    function logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function logic [63:0] sext(longint v);
        return v;
    endfunction

    // Pick a plausible lens, an extreme corner, or raw noise for the registers.
    task pick_setting();
        int kind;
        kind = $urandom_range(0, 5);
        if (kind <= 3) begin
            load_setting(sext(65536 + $signed($urandom_range(0, 8000)) - 4000),
                         sext($signed($urandom_range(0, 4000)) - 2000),
                         sext($signed($urandom_range(0, 4000)) - 2000),
                         {16'd0, 16'($urandom_range(0, 4095)), 16'd0,
                          16'($urandom_range(0, 4095))},
                         sext(-longint'($urandom_range(50, 3000)) << 16),
                         sext(longint'($signed({$urandom(), 6'd0})) ),
                         sext(longint'($signed($urandom())) >>> 6),
                         sext(longint'($signed($urandom())) >>> 18));
        end else if (kind == 4) begin
            load_setting(rand64(), rand64(), rand64(), rand64(),
                         rand64(), rand64(), rand64(), rand64());
        end else begin
            load_setting({32'd0, $urandom()}, {32'd0, $urandom()}, {32'd0, $urandom()},
                         rand64(), {32'd0, $urandom()},
                         rand64() >> $urandom_range(0, 63),
                         rand64() >> $urandom_range(0, 63),
                         rand64() >> $urandom_range(0, 63));
        end
    endtask

    task random_pixels(int count);
        int          burst;
        int          pick;
        logic [15:0] row, col;
        for (int n = 0; n < count; ) begin
            burst = $urandom_range(1, 48);
            for (int b = 0; b < burst && n < count; b++, n++) begin
                pick = $urandom_range(0, 9);
                if (pick < 8) begin
                    row = 16'($urandom_range(0, 65520));
                    col = 16'($urandom_range(0, 65520));
                end else begin
                    row = 16'($urandom());
                    col = 16'($urandom());
                end
                send_pixel(row, col, 24'($urandom()));
            end
            // Gaps of zero keep valid high straight across the burst boundary.
            if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 12));
        end
    endtask

    initial begin
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Defaults: Z is zero everywhere, so theta sits at pi/2.
        send_pixel(16'd0, 16'd0, 24'h000000);          // radius zero
        send_pixel(16'hFFFF, 16'hFFFF, 24'hFFFFFF);    // clamp both axes
        send_pixel(16'd65520, 16'd0, 24'hA5A5A5);
        send_pixel(16'd0, 16'd65521, 24'h5A5A5A);
        send_pixel(16'd16, 16'd16, 24'h123456);
        send_pixel(16'd1, 16'd0, 24'hFEDCBA);
        drain();

        // Offset centre: pixels left of it on the row axis give phi of 2pi.
        load_setting(64'd65536, 64'd0, 64'd0, {32'd100 << 16, 32'd50 << 16},
                     sext(-(longint'(500) << 16)), 64'd0, 64'd0, 64'd0);
        send_pixel(16'd0, 16'd800, 24'h010203);        // Y zero, X negative
        send_pixel(16'd1600, 16'd800, 24'h040506);     // exactly at the centre
        send_pixel(16'd3200, 16'd800, 24'h070809);     // Y zero, X positive
        send_pixel(16'd1600, 16'd0, 24'h0A0B0C);
        send_pixel(16'd1600, 16'd1600, 24'h0D0E0F);
        send_pixel(16'd0, 16'd0, 24'h101112);
        drain();

        // Tiny gain: radius below a sixteenth, theta at or near pi with negative Z.
        load_setting(64'd1, 64'd0, 64'd0, 64'd0, sext(-65536), 64'd0, 64'd0, 64'd0);
        send_pixel(16'd5, 16'd0, 24'h131415);
        send_pixel(16'd15, 16'd0, 24'h161718);
        send_pixel(16'd65535, 16'd0, 24'h191A1B);
        drain();

        // Extremes: drive the polynomial into saturation both ways.
        load_setting(64'h8000_0000, 64'h7FFF_FFFF, 64'h8000_0000, '1,
                     64'h7FFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF,
                     64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF);
        send_pixel(16'd0, 16'd0, 24'h202122);
        send_pixel(16'hFFFF, 16'hFFFF, 24'h232425);
        send_pixel(16'd4000, 16'd60000, 24'h262728);
        drain();
        load_setting(64'h7FFF_FFFF, 64'h8000_0000, 64'h7FFF_FFFF, 64'd0,
                     64'h8000_0000, 64'h8000_0000_0000_0000,
                     64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
        send_pixel(16'd0, 16'd0, 24'h292A2B);
        send_pixel(16'hFFFF, 16'hFFFF, 24'h2C2D2E);
        send_pixel(16'd7, 16'd9, 24'h2F3031);
        drain();

        // Random phases, each under its own setting.
        for (int phase = 0; phase < 7; phase++) begin
            pick_setting();
            random_pixels(125);
            // Pause with nothing in flight, then carry on under the same setting.
            s_tvalid <= 1'b0;
            while (rays.pending() != 0) @(negedge aclk);
            random_pixels(125);
            drain();
        end

        $display("covered %0d pixel transactions over %0d register settings, %0d rays checked",
                 pixels_sent, settings_used, rays.checked);
        $display("included centre hits, clamped positions, saturated polynomials, tiny radii");
        if (rays.errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("timeout with %0d rays still owed", rays.pending());
        $display("end of test: mismatches");
        $finish;
    end
endmodule

FILE: sim.f
+incdir+design
design/fpsa_pkg.sv
design/fpsa_cordic.sv
design/fisheye_pixel_to_sphere_angles_top.sv
design/fpsa_checker.sv
bench/tb_top.sv
